FILE: hdl/mm_pkg.sv
// Package for the matrix multiply block: widths, codes, types and helpers.
// Depends on nothing; every other file of the block but mm_ram imports it.
`timescale 1ns / 1ps
`default_nettype none
package mm_pkg;
   localparam int MAX_DIM_DEFAULT    = 8;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int FUNC_W = 2;
   localparam int IDX_W  = 3;
   localparam int VAL_W  = 32;
   localparam int DIM_W  = 4;
   localparam int CFG_IDX_W = 2;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_START  = 2'd2;
   localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
   localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_FETCH, ST_MAC, ST_EMIT, ST_WAIT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic clear_acc;   // start a new element
      logic mac_en;      // accumulate the product of the registered reads
      logic emit;        // load the output register
      logic emit_err;    // load the output register with the error result
      logic [IDX_W-1:0] i;
      logic [IDX_W-1:0] j;
      logic last;
   } cmd_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d, input int lim);
      logic [DIM_W-1:0] l;
      l = DIM_W'(lim);
      return (d > l) ? l : d;
   endfunction
endpackage
`default_nettype wire

FILE: hdl/mm_if.sv
// Valid/ready stream interfaces for the matrix multiply block.
// Depends on mm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface mm_req_if import mm_pkg::*; ();
   logic valid, ready;
   logic [FUNC_W-1:0] func;
   logic [IDX_W-1:0] row, col;
   logic signed [VAL_W-1:0] value;
   modport source (output valid, func, row, col, value, input ready);
   modport sink (input valid, func, row, col, value, output ready);
endinterface

interface mm_rsp_if import mm_pkg::*; ();
   logic valid, ready;
   logic signed [VAL_W-1:0] result_value;
   logic [IDX_W-1:0] result_row, result_col;
   logic last, dim_error;
   modport source (output valid, result_value, result_row, result_col, last, dim_error,
                   input ready);
   modport sink (input valid, result_value, result_row, result_col, last, dim_error,
                 output ready);
endinterface

interface mm_csr_if import mm_pkg::*; ();
   logic valid, ready;
   logic [CFG_IDX_W-1:0] index;
   logic [DIM_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/mm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module mm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic clock,
   input  wire logic we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

FILE: hdl/mm_datapath.sv
// Datapath: A and B stores, multiply, saturating accumulator, output register.
// Depends on mm_pkg and mm_ram.
`timescale 1ns / 1ps
`default_nettype none
module mm_datapath import mm_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
   input  wire logic clock,
   input  wire logic we_a,
   input  wire logic we_b,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DATA_WIDTH-1:0] wdata,
   input  wire logic [AW-1:0] raddr_a,
   input  wire logic [AW-1:0] raddr_b,
   input  wire cmd_type cmd,
   input  wire logic out_load_ok,
   output logic signed [VAL_W-1:0] o_value,
   output logic [IDX_W-1:0] o_row,
   output logic [IDX_W-1:0] o_col,
   output logic o_last,
   output logic o_err
);
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int PW = 2 * DATA_WIDTH;
   logic [DATA_WIDTH-1:0] ra, rb;
   logic signed [PW-1:0] prod_ff;
   logic prod_v_ff;
   logic signed [63:0] acc_ff, acc_in, pext, sum;
   logic signed [47:0] shifted;
   logic signed [VAL_W-1:0] satv;
   logic signed [47:0] hi, lo;

   mm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_a (
      .clock, .we(we_a), .waddr, .wdata, .raddr(raddr_a), .rdata(ra));
   mm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_b (
      .clock, .we(we_b), .waddr, .wdata, .raddr(raddr_b), .rdata(rb));

   // Products are registered; mac_en marks a product stage holding a valid term.
   always_ff @(posedge clock) begin
      prod_ff <= $signed(ra) * $signed(rb);
      prod_v_ff <= cmd.mac_en;
   end

   always_comb begin
      pext = 64'(prod_ff);
      sum = acc_ff + pext;
      acc_in = sum;
      if (!acc_ff[63] && !pext[63] && sum[63]) acc_in = {1'b0, {63{1'b1}}};
      if (acc_ff[63] && pext[63] && !sum[63]) acc_in = {1'b1, 63'd0};
      if (!prod_v_ff) acc_in = acc_ff;
      if (cmd.clear_acc) acc_in = '0;
   end

   always_ff @(posedge clock) acc_ff <= acc_in;

   always_comb begin
      shifted = acc_ff[63:16];
      hi = 48'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
      lo = -hi - 48'sd1;
      if (shifted > hi) satv = VAL_W'(hi);
      else if (shifted < lo) satv = VAL_W'(lo);
      else satv = VAL_W'(shifted);
   end

   always_ff @(posedge clock) begin
      if (out_load_ok && cmd.emit) begin
         o_value <= cmd.emit_err ? '0 : satv;
         o_row <= cmd.emit_err ? '0 : cmd.i;
         o_col <= cmd.emit_err ? '0 : cmd.j;
         o_last <= cmd.last;
         o_err <= cmd.emit_err;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/mm_ctrl.sv
// Controller: dimension check and the i, j, k walk of the product.
// Depends on mm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mm_ctrl import mm_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT,
   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [DIM_W-1:0] m,
   input  wire logic [DIM_W-1:0] n,
   input  wire logic [DIM_W-1:0] br,
   input  wire logic [DIM_W-1:0] bc,
   input  wire logic out_busy,
   output logic idle,
   output logic [AW-1:0] raddr_a,
   output logic [AW-1:0] raddr_b,
   output cmd_type cmd,
   output logic out_load
);
   state_type state_ff, state_in;
   logic [DIM_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, outc_ff, outc_in;
   logic col_ff, col_in;
   logic [1:0] drain_ff, drain_in;
   logic as_col, err;
   logic [DIM_W-1:0] inner;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      outc_ff <= outc_in; col_ff <= col_in; drain_ff <= drain_in;
   end

   always_comb begin
      as_col = (br == 4'd1) && (bc == n);
      inner = as_col ? bc : br;
      err = (m == 0) || (n == 0) || (br == 0) || (bc == 0) || (inner != n);
   end

   always_comb begin
      state_in = state_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff;
      outc_in = outc_ff; col_in = col_ff; drain_in = drain_ff;
      cmd = '0;
      cmd.i = i_ff[IDX_W-1:0];
      cmd.j = j_ff[IDX_W-1:0];
      cmd.last = (i_ff == m - 4'd1) && (j_ff == outc_ff - 4'd1);
      out_load = 1'b0;
      idle = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            i_in = '0; j_in = '0; k_in = '0;
            col_in = as_col;
            outc_in = as_col ? 4'd1 : bc;
            if (err) begin
               if (!out_busy) begin
                  cmd.emit = 1'b1; cmd.emit_err = 1'b1; cmd.last = 1'b1;
                  out_load = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.clear_acc = 1'b1;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            // Read issued at k last cycle; its data is valid now.
            cmd.mac_en = 1'b1;
            if (k_ff == n - 4'd1) begin
               drain_in = 2'd2;
               state_in = ST_WAIT;
            end else begin
               k_in = k_ff + 4'd1;
            end
         end
         ST_WAIT: begin
            drain_in = drain_ff - 2'd1;
            if (drain_ff == 2'd1) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_busy) begin
               cmd.emit = 1'b1;
               out_load = 1'b1;
               k_in = '0;
               if (cmd.last) begin
                  state_in = ST_IDLE;
               end else if (j_ff == outc_ff - 4'd1) begin
                  j_in = '0; i_in = i_ff + 4'd1; state_in = ST_FETCH;
               end else begin
                  j_in = j_ff + 4'd1; state_in = ST_FETCH;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // The stores are addressed with the next k, so the data of step k is
      // present in the cycle that raises mac_en for step k.
      raddr_a = AW'(32'(i_ff) * MAX_DIM + 32'(k_in));
      raddr_b = col_ff ? AW'(k_in) : AW'(32'(k_in) * MAX_DIM + 32'(j_ff));
   end
endmodule
`default_nettype wire

FILE: hdl/matrix_multiply.sv
// Matrix multiply top level: C = A x B on Q16.16 data from two 64-entry stores.
// Loads are taken while the controller idles and give no result. A start may
// wait on output stalls; the inner walk issues one read of each store and one
// multiply-accumulate per cycle. A dimension error answers with one error result.
// Reset (synchronous, active high) clears control and sets all dimensions
// to 1; the stores keep their contents and are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module matrix_multiply import mm_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   mm_req_if.sink req,
   mm_rsp_if.source rsp,
   mm_csr_if.sink csr
);
   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
   localparam int LIM = (MAX_DIM < 8) ? MAX_DIM : 8;

   logic [DIM_W-1:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic idle, out_load, out_busy, req_fire, in_range;
   logic [AW-1:0] raddr_a, raddr_b, waddr;
   cmd_type cmd;

   // Configuration is always accepted; the host must write it only while no
   // product is in flight, which the block does not enforce.
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= 4'd1; a_cols_ff <= 4'd1; b_rows_ff <= 4'd1; b_cols_ff <= 4'd1;
      end else if (csr.valid) begin
         case (csr.index)
            REG_A_ROWS: a_rows_ff <= csr.data;
            REG_A_COLS: a_cols_ff <= csr.data;
            REG_B_ROWS: b_rows_ff <= csr.data;
            REG_B_COLS: b_cols_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // Loads stream in while the controller idles; a start hands over to it.
   assign req.ready = idle;
   assign req_fire = req.valid && idle;
   assign in_range = (32'(req.row) < MAX_DIM) && (32'(req.col) < MAX_DIM);
   assign waddr = AW'(32'(req.row) * MAX_DIM + 32'(req.col));

   // The output register holds one result; a new one loads only once it is taken.
   assign out_busy = rsp_valid_ff && !rsp.ready;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) rsp_valid_in = 1'b0;
      if (out_load) rsp_valid_in = 1'b1;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end
   assign rsp.valid = rsp_valid_ff;

   mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock, .reset,
      .start(req_fire && req.func == FUNC_START),
      .m(eff_dim(a_rows_ff, LIM)), .n(eff_dim(a_cols_ff, LIM)),
      .br(eff_dim(b_rows_ff, LIM)), .bc(eff_dim(b_cols_ff, LIM)),
      .out_busy, .idle, .raddr_a, .raddr_b, .cmd, .out_load);

   mm_datapath #(.MAX_DIM(MAX_DIM), .DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock,
      .we_a(req_fire && in_range && req.func == FUNC_LOAD_A),
      .we_b(req_fire && in_range && req.func == FUNC_LOAD_B),
      .waddr, .wdata(req.value[DATA_WIDTH-1:0]),
      .raddr_a, .raddr_b, .cmd, .out_load_ok(out_load),
      .o_value(rsp.result_value), .o_row(rsp.result_row), .o_col(rsp.result_col),
      .o_last(rsp.last), .o_err(rsp.dim_error));
endmodule
`default_nettype wire

FILE: hdl/mm_checker.sv
// Port-level checker for matrix_multiply, bound to the top level.
// Depends on mm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
module mm_checker import mm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_last,
   input wire logic rsp_dim_error,
   input wire logic signed [VAL_W-1:0] rsp_value
);
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dim_error |-> rsp_last && rsp_value == 0)
      else $error("error result not marked last or nonzero");
   a_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("stalled result changed");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input accepted in the middle of a run");
endmodule

bind matrix_multiply mm_checker u_chk (
   .clock, .reset, .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_last(rsp.last),
   .rsp_dim_error(rsp.dim_error), .rsp_value(rsp.result_value));
`default_nettype wire
